>>> rtl/core/pcm_ring_fifo_with_gain_top_assert.svh
// Assertion macros for the PCM ring FIFO.
`ifndef PCM_RING_FIFO_WITH_GAIN_TOP_ASSERT_SVH
`define PCM_RING_FIFO_WITH_GAIN_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PRFG_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PRFG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PRFG_ASSERT_NOW(lbl, prop, msg)
`define PRFG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/prfg_pkg.sv
package prfg_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 18;
	localparam int CFG_AW   = 3;
	localparam int GAIN_W   = 16;
	localparam int CAP_W    = 16;
	localparam int RATE_W   = 18;
	localparam int CH_W     = 4;
	localparam int DEN_W    = RATE_W + CH_W;
	localparam int MS_W     = 25;
	localparam int MS_SCALE_W = 10;
	localparam int MS_PER_S = 1000;
	localparam int PROD_W   = 31;

	localparam logic [GAIN_W-1:0] GAIN_RST = 16'd32768;
	localparam logic [CAP_W-1:0]  CAP_RST  = 16'd32768;
	localparam logic [RATE_W-1:0] RATE_RST = 18'd44100;
	localparam logic [CH_W-1:0]   CH_RST   = 4'd2;

	localparam logic [SAMPLE_W-1:0] SAMPLE_POS_MAX = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_MAG = 16'h8000;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [CFG_AW-1:0] {
		REG_ENABLED  = 3'd0,
		REG_GAIN     = 3'd1,
		REG_CAPACITY = 3'd2,
		REG_RATE     = 3'd3,
		REG_CHANNELS = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic fetch;
		logic step;
	} prfg_cmd_t;

	typedef struct packed {
		logic div_last;
	} prfg_stat_t;

endpackage

>>> rtl/core/prfg_ram.sv
module prfg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/prfg_ctrl.sv
module prfg_ctrl import prfg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  prfg_stat_t stat,
	output prfg_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_FETCH = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC:  state_d = ST_FETCH;
			ST_FETCH: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.fetch   = (state_q == ST_FETCH);
	assign cmd.step    = (state_q == ST_DIV);
	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_DONE);

endmodule

>>> rtl/core/prfg_dp.sv
module prfg_dp import prfg_pkg::*; #(
	parameter int DEPTH = 32768
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  prfg_cmd_t                  cmd,
	output prfg_stat_t                 stat,
	input  logic [1:0]                 mode,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       cfg_we,
	input  logic [CFG_AW-1:0]          cfg_addr,
	input  logic [CFG_W-1:0]           cfg_wdata,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       underrun,
	output logic                       dropped,
	output logic [15:0]                fill_level,
	output logic [MS_W-1:0]            buffered_ms
);

	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int NW    = FW + MS_SCALE_W;
	localparam int CNT_W = $clog2(NW);
	localparam logic [CAP_W:0] DEPTH_L = (CAP_W + 1)'(DEPTH);

	logic                enabled_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [CAP_W-1:0]    capacity_q;
	logic [RATE_W-1:0]   rate_q;
	logic [CH_W-1:0]     ch_q;

	mode_t               mode_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [AW-1:0]       wr_idx_q, rd_idx_q;
	logic [FW-1:0]       fill_q;
	logic [FW-1:0]       cap_eff;
	logic [FW-1:0]       wr_inc, rd_inc;
	logic [AW-1:0]       wr_next, rd_next;
	logic                full, empty, wr_ok, rd_ok;

	logic [SAMPLE_W-1:0] rd_data, raw;
	logic                under_q, drop_q;
	logic [SAMPLE_W-1:0] raw_q, mag_q;
	logic                neg_q, unity_q;
	logic [GAIN_W-2:0]   g_q;
	logic [PROD_W-1:0]   product_q;
	logic [SAMPLE_W-1:0] scaled_mag, sout;

	logic [DEN_W-1:0]    den_q, rem_q;
	logic [NW-1:0]       quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DEN_W:0]      shifted, diff;
	logic [MS_W-1:0]     ms_sat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			gain_q     <= GAIN_RST;
			capacity_q <= CAP_RST;
			rate_q     <= RATE_RST;
			ch_q       <= CH_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ENABLED:  enabled_q  <= cfg_wdata[0];
				REG_GAIN:     gain_q     <= cfg_wdata[GAIN_W-1:0];
				REG_CAPACITY: capacity_q <= cfg_wdata[CAP_W-1:0];
				REG_RATE:     rate_q     <= cfg_wdata[RATE_W-1:0];
				REG_CHANNELS: ch_q       <= cfg_wdata[CH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = FW'(1);
		end else if ({1'b0, capacity_q} > DEPTH_L) begin
			cap_eff = FW'(DEPTH);
		end else begin
			cap_eff = FW'(capacity_q);
		end
	end

	assign wr_inc  = FW'(wr_idx_q) + FW'(1);
	assign rd_inc  = FW'(rd_idx_q) + FW'(1);
	assign wr_next = (wr_inc >= cap_eff) ? '0 : wr_inc[AW-1:0];
	assign rd_next = (rd_inc >= cap_eff) ? '0 : rd_inc[AW-1:0];
	assign full    = (fill_q >= cap_eff);
	assign empty   = (fill_q == '0);
	assign wr_ok   = (mode_q == MODE_WRITE) && enabled_q && !full;
	assign rd_ok   = (mode_q == MODE_READ) && !empty;

	prfg_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.exec && wr_ok),
		.waddr(wr_idx_q),
		.wdata(sample_q),
		.re   (cmd.exec && rd_ok),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
		end else if (cmd.exec) begin
			case (mode_q)
				MODE_WRITE: begin
					if (wr_ok) begin
						wr_idx_q <= wr_next;
						fill_q   <= fill_q + FW'(1);
					end
				end
				MODE_READ: begin
					if (rd_ok) begin
						rd_idx_q <= rd_next;
						fill_q   <= fill_q - FW'(1);
					end
				end
				MODE_CLEAR: begin
					wr_idx_q <= '0;
					rd_idx_q <= '0;
					fill_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	assign raw = ((mode_q == MODE_READ) && !under_q) ? rd_data : '0;

	// request payload, gain path, divider data
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= mode_t'(mode);
			sample_q <= sample_in;
		end
		if (cmd.exec) begin
			under_q <= (mode_q == MODE_READ) && empty;
			drop_q  <= (mode_q == MODE_WRITE) && !wr_ok;
			den_q   <= DEN_W'(rate_q) * DEN_W'(ch_q);
		end
		if (cmd.fetch) begin
			raw_q   <= raw;
			neg_q   <= raw[SAMPLE_W-1];
			mag_q   <= raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
			unity_q <= gain_q[GAIN_W-1];
			g_q     <= gain_q[GAIN_W-2:0];
			rem_q   <= '0;
			quo_q   <= NW'(fill_q) * NW'(MS_PER_S);
		end
		if (cmd.step) begin
			product_q <= PROD_W'(mag_q) * PROD_W'(g_q);
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.fetch) begin
			cnt_q <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign shifted       = {rem_q, quo_q[NW-1]};
	assign diff          = shifted - {1'b0, den_q};
	assign stat.div_last = (cnt_q == CNT_W'(NW - 1));

	generate
		if (NW > MS_W) begin : g_ms_sat
			assign ms_sat = (|quo_q[NW-1:MS_W]) ? '1 : quo_q[MS_W-1:0];
		end else begin : g_ms_ext
			assign ms_sat = MS_W'(quo_q);
		end
	endgenerate

	assign scaled_mag = product_q[PROD_W-1:GAIN_W-1];

	always_comb begin
		if (unity_q) begin
			sout = raw_q;
		end else if (neg_q) begin
			sout = (scaled_mag > SAMPLE_NEG_MAG) ? SAMPLE_NEG_MAG
				: (~scaled_mag + SAMPLE_W'(1));
		end else begin
			sout = scaled_mag[SAMPLE_W-1] ? SAMPLE_POS_MAX : scaled_mag;
		end
	end

	assign sample_out  = sout;
	assign underrun    = under_q;
	assign dropped     = drop_q;
	assign fill_level  = 16'(fill_q);
	assign buffered_ms = (den_q == '0) ? '0 : ms_sat;

endmodule

>>> rtl/core/pcm_ring_fifo_with_gain_top.sv
// Channel   | Ports                                         | Handshake
// request   | start, busy, mode, sample_in                  | taken when start && !busy
// result    | done, sample_out, underrun, dropped,          | one-cycle strobe on done
//           | fill_level, buffered_ms                       |
// config    | cfg_we, cfg_addr, cfg_wdata                   | written when cfg_we
//
// A request steps through the EXEC, FETCH, DIV and DONE states; in DIV the divider for buffered
// time yields one quotient bit per cycle, and busy drops the cycle after done.
// The sample store is a single RAM; no clearing pass, ready right after reset.
// Results cannot be stalled; done is high for exactly one cycle.
`include "pcm_ring_fifo_with_gain_top_assert.svh"

module pcm_ring_fifo_with_gain_top import prfg_pkg::*; #(
	parameter int DEPTH = 32768
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 mode,
	input  logic signed [SAMPLE_W-1:0] sample_in,
	input  logic                       cfg_we,
	input  logic [CFG_AW-1:0]          cfg_addr,
	input  logic [CFG_W-1:0]           cfg_wdata,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] sample_out,
	output logic                       underrun,
	output logic                       dropped,
	output logic [15:0]                fill_level,
	output logic [MS_W-1:0]            buffered_ms
);

	prfg_cmd_t  cmd;
	prfg_stat_t stat;

	prfg_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	prfg_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.mode       (mode),
		.sample_in  (sample_in),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.sample_out (sample_out),
		.underrun   (underrun),
		.dropped    (dropped),
		.fill_level (fill_level),
		.buffered_ms(buffered_ms)
	);

	`PRFG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`PRFG_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done not a single-cycle strobe")
	`PRFG_ASSERT_NOW(a_flags_excl, !(done && underrun && dropped), "underrun and drop together")
	`PRFG_ASSERT_NOW(a_under_silent, (done && underrun) |-> (sample_out == '0), "underrun not silent")

endmodule
